// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, sampled on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/apkc_pkg.sv
// ----------------------------------------------------------------------------
// apkc_pkg
// Types and constants for the auto power keep-alive controller.
// ----------------------------------------------------------------------------
package apkc_pkg;

    typedef enum logic [1:0] {
        POS_OFF  = 2'd0,
        POS_ON   = 2'd1,
        POS_AUTO = 2'd2
    } pos_t;

    typedef enum logic [1:0] {
        LED_OFF  = 2'd0,
        LED_ON   = 2'd1,
        LED_SLOW = 2'd2,
        LED_FAST = 2'd3
    } led_mode_t;

    localparam logic [2:0] REG_SETTLE_TICKS     = 3'd0;
    localparam logic [2:0] REG_RECHECK_TICKS    = 3'd1;
    localparam logic [2:0] REG_SHUTDOWN_TICKS   = 3'd2;
    localparam logic [2:0] REG_MOTION_LIMIT     = 3'd3;
    localparam logic [2:0] REG_SLOW_BLINK_TICKS = 3'd4;
    localparam logic [2:0] REG_FAST_BLINK_TICKS = 3'd5;
    localparam logic [2:0] REG_ACCEL_PRESENT    = 3'd6;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 15;

    // battery scale 18.32 in Q8
    localparam logic [22:0] BAT_SCALE         = 23'd4690;
    localparam logic [15:0] RELAY_ON_OFFSET   = 16'd568;
    localparam logic [15:0] RELAY_OFF_OFFSET  = 16'd320;
    localparam logic [15:0] REF_OFFSET        = 16'd12000;
    localparam logic [15:0] LED_HOLD_COUNT    = 16'hFFFF;
    localparam logic [15:0] KEEPALIVE_EXTRA   = 16'd10;
    localparam logic [7:0]  IDLE_RECHECK      = 8'd3;

    typedef struct packed {
        logic [3:0]  settle_ticks;
        logic [7:0]  recheck_ticks;
        logic [14:0] shutdown_ticks;
        logic [14:0] motion_limit;
        logic [7:0]  slow_blink_ticks;
        logic [7:0]  fast_blink_ticks;
        logic        accel_present;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        settle_ticks:     4'd3,
        recheck_ticks:    8'd9,
        shutdown_ticks:   15'd1800,
        motion_limit:     15'd100,
        slow_blink_ticks: 8'd6,
        fast_blink_ticks: 8'd2,
        accel_present:    1'b1
    };

    typedef struct packed {
        pos_t               chosen_position;
        logic [3:0]         settle_count;
        logic [7:0]         recheck_count;
        logic [15:0]        keepalive_count;
        led_mode_t          led_mode;
        logic [15:0]        led_count;
        logic               led_level;
        logic               relay_level;
        logic signed [15:0] prev_x;
        logic signed [15:0] prev_y;
        logic signed [15:0] prev_z;
        logic               baseline_loaded;
    } state_t;

    localparam state_t STATE_RESET = '{
        chosen_position: POS_OFF,
        settle_count:    4'd0,
        recheck_count:   8'd0,
        keepalive_count: 16'd0,
        led_mode:        LED_OFF,
        led_count:       16'd0,
        led_level:       1'b0,
        relay_level:     1'b0,
        prev_x:          16'sd0,
        prev_y:          16'sd0,
        prev_z:          16'sd0,
        baseline_loaded: 1'b0
    };

    typedef struct packed {
        logic               auto_contact_low;
        logic               on_contact_low;
        logic [9:0]         battery_sample;
        logic [9:0]         reference_sample;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
    } tick_t;

    typedef struct packed {
        logic relay_on;
        logic led_on;
        logic sleep_allowed;
    } result_t;

endpackage

// File: hdl/apkc_tick.sv
// ----------------------------------------------------------------------------
// apkc_tick
// Next-state and result logic for one wake tick.
// ----------------------------------------------------------------------------
module apkc_tick
(
    input  apkc_pkg::cfg_t    cfg,
    input  apkc_pkg::state_t  st,
    input  apkc_pkg::tick_t   tick,
    output apkc_pkg::state_t  st_next,
    output apkc_pkg::result_t res
);

    logic [22:0]        bat_product;
    logic [15:0]        bat_value;
    logic [15:0]        ref_value;
    logic               charging;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic signed [15:0] base_z;
    logic signed [16:0] diff_x;
    logic signed [16:0] diff_y;
    logic signed [16:0] diff_z;
    logic [16:0]        mag_x;
    logic [16:0]        mag_y;
    logic [16:0]        mag_z;
    logic [16:0]        threshold;
    logic               moving;
    logic [15:0]        shutdown;
    apkc_pkg::pos_t     pos;

    assign bat_product = 23'(tick.battery_sample) * apkc_pkg::BAT_SCALE;
    assign bat_value   = 16'(bat_product[22:8])
                       + (st.relay_level ? apkc_pkg::RELAY_ON_OFFSET
                                         : apkc_pkg::RELAY_OFF_OFFSET);
    assign ref_value   = {5'd0, tick.reference_sample, 1'b0} + apkc_pkg::REF_OFFSET;
    assign charging    = bat_value > ref_value;

    // first tick after reset compares against its own sample
    assign base_x = st.baseline_loaded ? st.prev_x : tick.accel_x;
    assign base_y = st.baseline_loaded ? st.prev_y : tick.accel_y;
    assign base_z = st.baseline_loaded ? st.prev_z : tick.accel_z;

    assign diff_x = {tick.accel_x[15], tick.accel_x} - {base_x[15], base_x};
    assign diff_y = {tick.accel_y[15], tick.accel_y} - {base_y[15], base_y};
    assign diff_z = {tick.accel_z[15], tick.accel_z} - {base_z[15], base_z};

    assign mag_x = diff_x[16] ? 17'(-diff_x) : 17'(diff_x);
    assign mag_y = diff_y[16] ? 17'(-diff_y) : 17'(diff_y);
    assign mag_z = diff_z[16] ? 17'(-diff_z) : 17'(diff_z);

    assign threshold = {2'b00, cfg.motion_limit};
    assign moving    = cfg.accel_present
                     && ((mag_x > threshold) || (mag_y > threshold) || (mag_z > threshold));

    assign shutdown = {1'b0, cfg.shutdown_ticks};

    always_comb
    begin
        if (!tick.auto_contact_low && !tick.on_contact_low)
        begin
            pos = apkc_pkg::POS_OFF;
        end
        else if (tick.on_contact_low)
        begin
            pos = apkc_pkg::POS_ON;
        end
        else
        begin
            pos = apkc_pkg::POS_AUTO;
        end
    end

    always_comb
    begin
        logic [15:0] ka;
        logic [15:0] ka_left;
        logic        sleep_ok;

        st_next  = st;
        sleep_ok = 1'b1;
        ka       = st.keepalive_count;
        ka_left  = ka - 16'd1;

        if (!st.baseline_loaded)
        begin
            st_next.prev_x          = tick.accel_x;
            st_next.prev_y          = tick.accel_y;
            st_next.prev_z          = tick.accel_z;
            st_next.baseline_loaded = 1'b1;
        end

        if (pos != st.chosen_position)
        begin
            st_next.chosen_position = pos;
            st_next.settle_count    = cfg.settle_ticks;
        end

        if (st_next.settle_count != 4'd0)
        begin
            st_next.settle_count = st_next.settle_count - 4'd1;
        end
        else
        begin
            unique case (st_next.chosen_position)
                apkc_pkg::POS_ON:
                begin
                    st_next.relay_level     = 1'b1;
                    st_next.led_mode        = apkc_pkg::LED_ON;
                    st_next.led_count       = 16'd0;
                    st_next.keepalive_count = 16'd0;
                    sleep_ok                = 1'b0;
                end
                apkc_pkg::POS_AUTO:
                begin
                    if (st.recheck_count != 8'd0)
                    begin
                        st_next.recheck_count = st.recheck_count - 8'd1;
                    end
                    else if (charging)
                    begin
                        st_next.recheck_count = cfg.recheck_ticks;
                        if (st.led_mode != apkc_pkg::LED_SLOW)
                        begin
                            st_next.led_mode  = apkc_pkg::LED_SLOW;
                            st_next.led_count = 16'd0;
                        end
                        ka = (ka != 16'd0) ? shutdown : shutdown + apkc_pkg::KEEPALIVE_EXTRA;
                    end
                    else if (ka != 16'd0)
                    begin
                        if (cfg.accel_present)
                        begin
                            st_next.prev_x = tick.accel_x;
                            st_next.prev_y = tick.accel_y;
                            st_next.prev_z = tick.accel_z;
                        end
                        if (moving)
                        begin
                            st_next.recheck_count = cfg.recheck_ticks;
                            if (st.led_mode != apkc_pkg::LED_FAST)
                            begin
                                st_next.led_mode  = apkc_pkg::LED_FAST;
                                st_next.led_count = 16'd0;
                            end
                            ka = shutdown;
                        end
                        else
                        begin
                            st_next.led_mode      = apkc_pkg::LED_OFF;
                            st_next.led_count     = 16'd0;
                            st_next.recheck_count = apkc_pkg::IDLE_RECHECK;
                        end
                    end

                    ka_left = ka - 16'd1;
                    if (ka != 16'd0)
                    begin
                        st_next.keepalive_count = ka_left;
                        // relay holds its level while still above the grant
                        if (ka_left <= shutdown)
                        begin
                            st_next.relay_level = 1'b1;
                        end
                        sleep_ok = 1'b0;
                    end
                    else
                    begin
                        st_next.keepalive_count = 16'd0;
                        st_next.relay_level     = 1'b0;
                        sleep_ok                = 1'b1;
                    end
                end
                default:
                begin
                    st_next.relay_level     = 1'b0;
                    st_next.led_mode        = apkc_pkg::LED_OFF;
                    st_next.led_count       = 16'd0;
                    st_next.keepalive_count = 16'd0;
                    sleep_ok                = 1'b1;
                end
            endcase

            if (st_next.led_count == 16'd0)
            begin
                unique case (st_next.led_mode)
                    apkc_pkg::LED_OFF:
                    begin
                        st_next.led_level = 1'b0;
                        st_next.led_count = apkc_pkg::LED_HOLD_COUNT;
                    end
                    apkc_pkg::LED_ON:
                    begin
                        st_next.led_level = 1'b1;
                        st_next.led_count = apkc_pkg::LED_HOLD_COUNT;
                    end
                    apkc_pkg::LED_SLOW:
                    begin
                        st_next.led_level = ~st_next.led_level;
                        st_next.led_count = 16'(cfg.slow_blink_ticks);
                    end
                    apkc_pkg::LED_FAST:
                    begin
                        st_next.led_level = ~st_next.led_level;
                        st_next.led_count = 16'(cfg.fast_blink_ticks);
                    end
                    default:
                    begin
                        st_next.led_level = 1'b0;
                        st_next.led_count = apkc_pkg::LED_HOLD_COUNT;
                    end
                endcase
            end
            else
            begin
                st_next.led_count = st_next.led_count - 16'd1;
            end
        end

        res.relay_on      = st_next.relay_level;
        res.led_on        = st_next.led_level;
        res.sleep_allowed = sleep_ok;
    end

endmodule

// File: hdl/auto_power_keepalive_controller_core.sv
// Path: an accepted item is captured in the input register and moves through
// the tick logic into the result register, which drives the outputs.
// Throughput: one item per cycle unless out_stall holds a valid result; the
// tick logic sits between the input register and the result register, and the
// controller state updates as the item leaves the input register.
// Reset (rst_n low, asynchronous): state, configuration defaults and valids.
// ----------------------------------------------------------------------------
// auto_power_keepalive_controller_core
// Switch debounce, charge and motion keep-alive, relay and LED control.
// ----------------------------------------------------------------------------
module auto_power_keepalive_controller_core
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [apkc_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [apkc_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 auto_contact_low,
    input  logic                                 on_contact_low,
    input  logic [9:0]                           battery_sample,
    input  logic [9:0]                           reference_sample,
    input  logic signed [15:0]                   accel_x,
    input  logic signed [15:0]                   accel_y,
    input  logic signed [15:0]                   accel_z,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 relay_on,
    output logic                                 led_on,
    output logic                                 sleep_allowed
);

    apkc_pkg::cfg_t    cfg_reg;
    apkc_pkg::state_t  st_reg;
    apkc_pkg::state_t  st_next;
    apkc_pkg::tick_t   tick_reg;
    apkc_pkg::result_t res_next;
    apkc_pkg::result_t res_reg;
    logic              tick_valid_reg;
    logic              out_valid_reg;
    logic              advance;
    logic              accept;

    assign advance  = tick_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = tick_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    apkc_tick u_tick
    (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .tick    (tick_reg),
        .st_next (st_next),
        .res     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= apkc_pkg::CFG_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                apkc_pkg::REG_SETTLE_TICKS:     cfg_reg.settle_ticks     <= cfg_data[3:0];
                apkc_pkg::REG_RECHECK_TICKS:    cfg_reg.recheck_ticks    <= cfg_data[7:0];
                apkc_pkg::REG_SHUTDOWN_TICKS:   cfg_reg.shutdown_ticks   <= cfg_data[14:0];
                apkc_pkg::REG_MOTION_LIMIT:     cfg_reg.motion_limit     <= cfg_data[14:0];
                apkc_pkg::REG_SLOW_BLINK_TICKS: cfg_reg.slow_blink_ticks <= cfg_data[7:0];
                apkc_pkg::REG_FAST_BLINK_TICKS: cfg_reg.fast_blink_ticks <= cfg_data[7:0];
                apkc_pkg::REG_ACCEL_PRESENT:    cfg_reg.accel_present    <= cfg_data[0];
                default:                        cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            st_reg         <= apkc_pkg::STATE_RESET;
        end
        else
        begin
            if (accept)
            begin
                tick_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                tick_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_valid_reg <= 1'b1;
                st_reg        <= st_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tick_reg.auto_contact_low <= auto_contact_low;
            tick_reg.on_contact_low   <= on_contact_low;
            tick_reg.battery_sample   <= battery_sample;
            tick_reg.reference_sample <= reference_sample;
            tick_reg.accel_x          <= accel_x;
            tick_reg.accel_y          <= accel_y;
            tick_reg.accel_z          <= accel_z;
        end
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign relay_on      = res_reg.relay_on;
    assign led_on        = res_reg.led_on;
    assign sleep_allowed = res_reg.sleep_allowed;

endmodule

// File: hdl/apkc_checker.sv
// ----------------------------------------------------------------------------
// apkc_checker
// Port-level checks on the controller core's item channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module apkc_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic relay_on,
    input logic led_on,
    input logic sleep_allowed
);

    // held result keeps its payload
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(relay_on) && $stable(led_on) && $stable(sleep_allowed),
        "stalled result changed")

    // input side stalls only behind a stalled result
    `ASSERT_SAME(a_stall_cause, in_stall, out_valid && out_stall,
        "input stalled without output backpressure")

    // a fresh result follows an accepted item that passed through the input register
    `ASSERT_SAME(a_out_origin, $rose(out_valid), $past(in_valid && !in_stall, 2),
        "result without a matching item")

endmodule

bind auto_power_keepalive_controller_core apkc_checker u_apkc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .relay_on      (relay_on),
    .led_on        (led_on),
    .sleep_allowed (sleep_allowed)
);
